/* sv/aclint_pkg.sv */
package aclint_pkg;

	// Fixed widths of the request fields, the line count and the default hart count.
	localparam int WORD_W = 12;
	localparam int HART_W = 13;
	localparam int LINE_N = 4;
	localparam int HART_COUNT_DEF = 4;

	// Operation codes.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// Address space codes.
	localparam logic [1:0] SPACE_MTIMER = 2'd0;
	localparam logic [1:0] SPACE_MSWI   = 2'd1;
	localparam logic [1:0] SPACE_SSWI   = 2'd2;

	// Doubleword index of the read-only time counter in the timer space.
	localparam logic [WORD_W-1:0] TIME_WORD = 12'hfff;

	typedef struct packed {
		logic [1:0]  operation;
		logic [1:0]  space;
		logic [14:0] byte_offset;
		logic        access_wide;
		logic [63:0] write_data;
	} req_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic [3:0]  timer_irq_lines;
		logic [3:0]  machine_soft_irq_lines;
		logic [3:0]  super_soft_irq_lines;
	} rsp_t;

	// Full-register write of one compare value.
	typedef struct packed {
		logic              en;
		logic [WORD_W-1:0] word;
		logic [63:0]       value;
	} cmp_wr_t;

	// Write of one row of two software pending bits (harts 2r and 2r+1).
	typedef struct packed {
		logic              en;
		logic [WORD_W-1:0] row;
		logic [1:0]        bits;
	} soft_wr_t;

	// Clearing sweep over the upper store entries after reset.
	typedef struct packed {
		logic              en;
		logic [WORD_W-1:0] idx;
	} clr_t;

endpackage

/* sv/aclint_cmp_store.sv */
module aclint_cmp_store #(
	parameter int HART_COUNT = aclint_pkg::HART_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 rd_en,
	input  logic [aclint_pkg::WORD_W-1:0]        rd_word,
	input  aclint_pkg::cmp_wr_t                  wr,
	input  aclint_pkg::clr_t                     clr,
	output logic [63:0]                          rd_data,
	output logic [aclint_pkg::LINE_N-1:0][63:0]  cmp_lines
);
	import aclint_pkg::*;

	localparam int LINE_HARTS = (HART_COUNT < LINE_N) ? HART_COUNT : LINE_N;

	logic [63:0] cmp_q [LINE_HARTS];
	logic [63:0] lo_val;
	logic        hit;
	logic        hit_q;
	logic        hi_q;
	logic [63:0] fwd_q;
	logic [63:0] lo_q;
	logic [63:0] hi_rd;

	// Compare registers of the harts that drive interrupt lines.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int h = 0; h < LINE_HARTS; h++) begin
				cmp_q[h] <= '0;
			end
		end else if (wr.en) begin
			for (int h = 0; h < LINE_HARTS; h++) begin
				if (wr.word == WORD_W'(h)) begin
					cmp_q[h] <= wr.value;
				end
			end
		end
	end

	// Read select over the line harts.
	always_comb begin
		lo_val = '0;
		for (int h = 0; h < LINE_HARTS; h++) begin
			if (rd_word == WORD_W'(h)) begin
				lo_val = cmp_q[h];
			end
		end
	end

	// A write committed in the same cycle as the read is forwarded.
	assign hit = wr.en && (wr.word == rd_word);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			hit_q <= hit;
			fwd_q <= wr.value;
			lo_q  <= lo_val;
			hi_q  <= (rd_word >= WORD_W'(LINE_N));
		end
	end

	// Compare values of the remaining harts live in a memory.
	if (HART_COUNT > LINE_N) begin : g_hi
		localparam int HI_N = HART_COUNT - LINE_N;
		localparam int IW = (HI_N > 1) ? $clog2(HI_N) : 1;

		logic [63:0]   mem [HI_N];
		logic [63:0]   mem_rd_q;
		logic [IW-1:0] rd_idx;
		logic [IW-1:0] wr_idx;
		logic          wr_hi;

		assign rd_idx = IW'(rd_word - WORD_W'(LINE_N));
		assign wr_idx = IW'(wr.word - WORD_W'(LINE_N));
		assign wr_hi  = wr.en && (wr.word >= WORD_W'(LINE_N))
			&& (wr.word < WORD_W'(HART_COUNT));

		always_ff @(posedge clk) begin
			if (clr.en && (clr.idx < WORD_W'(HI_N))) begin
				mem[clr.idx[IW-1:0]] <= '0;
			end else if (wr_hi) begin
				mem[wr_idx] <= wr.value;
			end
			if (rd_en) begin
				mem_rd_q <= mem[rd_idx];
			end
		end

		assign hi_rd = mem_rd_q;
	end else begin : g_no_hi
		assign hi_rd = '0;
	end

	assign rd_data = hit_q ? fwd_q : (hi_q ? hi_rd : lo_q);

	// Compare values seen by the interrupt lines.
	for (genvar h = 0; h < LINE_N; h++) begin : g_lines
		if (h < LINE_HARTS) begin : g_on
			assign cmp_lines[h] = cmp_q[h];
		end else begin : g_off
			assign cmp_lines[h] = '0;
		end
	end

endmodule

/* sv/aclint_soft_store.sv */
module aclint_soft_store #(
	parameter int HART_COUNT = aclint_pkg::HART_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [aclint_pkg::WORD_W-1:0] rd_row,
	input  aclint_pkg::soft_wr_t          wr,
	input  aclint_pkg::clr_t              clr,
	output logic [1:0]                    rd_bits,
	output logic [aclint_pkg::LINE_N-1:0] lines
);
	import aclint_pkg::*;

	localparam int LINE_HARTS = (HART_COUNT < LINE_N) ? HART_COUNT : LINE_N;
	localparam int LO_ROWS = LINE_N / 2;

	logic [LINE_HARTS-1:0] pend_q;
	logic [LINE_N-1:0]     pend_ext;
	logic [1:0]            lo_val;
	logic                  hit;
	logic                  hit_q;
	logic                  hi_q;
	logic [1:0]            fwd_q;
	logic [1:0]            lo_q;
	logic [1:0]            hi_rd;

	// Pending bits of the harts that drive interrupt lines.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (wr.en) begin
			for (int h = 0; h < LINE_HARTS; h++) begin
				if (wr.row == WORD_W'(h / 2)) begin
					pend_q[h] <= wr.bits[h % 2];
				end
			end
		end
	end

	assign pend_ext = LINE_N'(pend_q);
	assign lines    = pend_ext;

	// Row select over the line harts.
	always_comb begin
		lo_val = '0;
		for (int r = 0; r < LO_ROWS; r++) begin
			if (rd_row == WORD_W'(r)) begin
				lo_val = pend_ext[2*r +: 2];
			end
		end
	end

	assign hit = wr.en && (wr.row == rd_row);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			hit_q <= hit;
			fwd_q <= wr.bits;
			lo_q  <= lo_val;
			hi_q  <= (rd_row >= WORD_W'(LO_ROWS));
		end
	end

	// Rows of the remaining harts live in a memory.
	if (HART_COUNT > LINE_N) begin : g_hi
		localparam int HI_ROWS = (HART_COUNT + 1) / 2 - LO_ROWS;
		localparam int IW = (HI_ROWS > 1) ? $clog2(HI_ROWS) : 1;

		logic [1:0]    mem [HI_ROWS];
		logic [1:0]    mem_rd_q;
		logic [IW-1:0] rd_idx;
		logic [IW-1:0] wr_idx;
		logic          wr_hi;

		assign rd_idx = IW'(rd_row - WORD_W'(LO_ROWS));
		assign wr_idx = IW'(wr.row - WORD_W'(LO_ROWS));
		assign wr_hi  = wr.en && (wr.row >= WORD_W'(LO_ROWS))
			&& (wr.row < WORD_W'(LO_ROWS + HI_ROWS));

		always_ff @(posedge clk) begin
			if (clr.en && (clr.idx < WORD_W'(HI_ROWS))) begin
				mem[clr.idx[IW-1:0]] <= '0;
			end else if (wr_hi) begin
				mem[wr_idx] <= wr.bits;
			end
			if (rd_en) begin
				mem_rd_q <= mem[rd_idx];
			end
		end

		assign hi_rd = mem_rd_q;
	end else begin : g_no_hi
		assign hi_rd = '0;
	end

	assign rd_bits = hit_q ? fwd_q : (hi_q ? hi_rd : lo_q);

endmodule

/* sv/aclint_exec.sv */
module aclint_exec #(
	parameter int HART_COUNT = aclint_pkg::HART_COUNT_DEF
) (
	input  aclint_pkg::req_t     item,
	input  logic [63:0]          time_value,
	input  logic [63:0]          cmp_old,
	input  logic [1:0]           msw_old,
	input  logic [1:0]           ssw_old,
	output logic [63:0]          read_data,
	output logic                 tick,
	output aclint_pkg::cmp_wr_t  cmp_wr,
	output aclint_pkg::soft_wr_t msw_wr,
	output aclint_pkg::soft_wr_t ssw_wr
);
	import aclint_pkg::*;

	logic [WORD_W-1:0] word;
	logic [HART_W-1:0] hart;
	logic              upper;
	logic              wide;
	logic              aligned;
	logic              is_rd;
	logic              is_wr;
	logic [63:0]       data;
	logic              t_time;
	logic              t_cmp;
	logic [63:0]       t_val;
	logic [63:0]       t_rd;
	logic [63:0]       t_new;
	logic              pres_n;
	logic              pres0;
	logic              pres1;
	logic [63:0]       m_rd;
	logic [63:0]       s_rd;
	logic [1:0]        m_new;
	logic [1:0]        s_new;
	logic              soft_en;

	// Read value of a software space row for the addressed word(s).
	function automatic logic [63:0] soft_read(input logic [1:0] row, input logic w,
		input logic up, input logic p_n, input logic p0, input logic p1);
		logic [63:0] r;
		r = '0;
		if (w) begin
			r[0]  = p0 & row[0];
			r[32] = p1 & row[1];
		end else begin
			r[0] = p_n & (up ? row[1] : row[0]);
		end
		return r;
	endfunction

	// New row value after a software space write.
	function automatic logic [1:0] soft_write(input logic [1:0] row, input logic w,
		input logic up, input logic [63:0] d);
		logic [1:0] r;
		if (w) begin
			r = {d[32], d[0]};
		end else if (up) begin
			r = {d[0], row[0]};
		end else begin
			r = {row[1], d[0]};
		end
		return r;
	endfunction

	// Address decode shared by all spaces.
	assign word    = item.byte_offset[14:3];
	assign hart    = item.byte_offset[14:2];
	assign upper   = item.byte_offset[2];
	assign wide    = item.access_wide;
	assign aligned = (item.byte_offset[1:0] == 2'b00) && !(wide && upper);
	assign is_rd   = (item.operation == OP_READ);
	assign is_wr   = (item.operation == OP_WRITE);
	assign tick    = (item.operation == OP_TICK);
	assign data    = wide ? item.write_data : {32'b0, item.write_data[31:0]};

	// Timer space: compare registers and the time counter.
	assign t_time = (word == TIME_WORD);
	assign t_cmp  = (word < WORD_W'(HART_COUNT)) && !t_time;
	assign t_val  = t_time ? time_value : cmp_old;

	always_comb begin
		if (wide) begin
			t_rd  = t_val;
			t_new = data;
		end else if (upper) begin
			t_rd  = {32'b0, t_val[63:32]};
			t_new = {data[31:0], cmp_old[31:0]};
		end else begin
			t_rd  = {32'b0, t_val[31:0]};
			t_new = {cmp_old[63:32], data[31:0]};
		end
	end

	// Software spaces: presence of the covered harts.
	assign pres_n = (hart < HART_W'(HART_COUNT));
	assign pres0  = ({word, 1'b0} < HART_W'(HART_COUNT));
	assign pres1  = ({word, 1'b1} < HART_W'(HART_COUNT));
	assign m_rd   = soft_read(msw_old, wide, upper, pres_n, pres0, pres1);
	assign s_rd   = soft_read(ssw_old, wide, upper, pres_n, pres0, pres1);
	assign m_new  = soft_write(msw_old, wide, upper, data);
	assign s_new  = soft_write(ssw_old, wide, upper, data);
	assign soft_en = is_wr && aligned && (wide ? pres0 : pres_n);

	// Read data by space; unmapped places and non-reads return zero.
	always_comb begin
		read_data = '0;
		if (is_rd && aligned) begin
			unique case (item.space)
				SPACE_MTIMER: begin
					if (t_time || t_cmp) begin
						read_data = t_rd;
					end
				end
				SPACE_MSWI: read_data = m_rd;
				SPACE_SSWI: read_data = s_rd;
				default:    read_data = '0;
			endcase
		end
	end

	// Write requests; the caller gates them with the commit strobe.
	assign cmp_wr.en    = is_wr && aligned && t_cmp && (item.space == SPACE_MTIMER);
	assign cmp_wr.word  = word;
	assign cmp_wr.value = t_new;
	assign msw_wr.en    = soft_en && (item.space == SPACE_MSWI);
	assign msw_wr.row   = word;
	assign msw_wr.bits  = m_new;
	assign ssw_wr.en    = soft_en && (item.space == SPACE_SSWI);
	assign ssw_wr.row   = word;
	assign ssw_wr.bits  = s_new;

endmodule

/* sv/riscv_aclint_timer_and_swi_unit.sv */
// Path: an accepted request goes through the input register, then the response register.
// Throughput: one request per cycle while each response is taken (rsp_ready) and no
// clearing pass runs; the read of the compare and pending stores is registered with the
// input stage, and same-cycle writes are forwarded.
// Reset: time, compares and pending bits read as zero; with more than four harts a
// clearing pass over the upper store entries runs after reset, during which req_ready is low.
module riscv_aclint_timer_and_swi_unit #(
	parameter int HART_COUNT = aclint_pkg::HART_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  aclint_pkg::req_t req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output aclint_pkg::rsp_t rsp
);
	import aclint_pkg::*;

	localparam int LINE_HARTS = (HART_COUNT < LINE_N) ? HART_COUNT : LINE_N;
	localparam bit HAS_HI = (HART_COUNT > LINE_N);
	localparam int CLR_N = HAS_HI ? HART_COUNT - LINE_N : 1;
	localparam logic [WORD_W-1:0] CLR_LAST = WORD_W'(CLR_N - 1);

	logic                     accept;
	logic                     commit;
	logic                     valid_s1;
	req_t                     item_s1;
	logic                     rsp_valid_q;
	logic [63:0]              rd_q;
	logic [63:0]              time_q;
	logic                     clearing_q;
	logic [WORD_W-1:0]        clr_cnt_q;
	clr_t                     clr;
	logic [63:0]              cmp_old;
	logic [LINE_N-1:0][63:0]  cmp_lines;
	logic [1:0]               msw_old;
	logic [1:0]               ssw_old;
	logic [LINE_N-1:0]        msw_lines;
	logic [LINE_N-1:0]        ssw_lines;
	logic [LINE_N-1:0]        timer_lines;
	logic [63:0]              x_read;
	logic                     x_tick;
	cmp_wr_t                  x_cmp_wr;
	soft_wr_t                 x_msw_wr;
	soft_wr_t                 x_ssw_wr;
	cmp_wr_t                  cmp_wr;
	soft_wr_t                 msw_wr;
	soft_wr_t                 ssw_wr;

	// Handshake: the input stage moves on when the response register is free.
	assign commit    = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !clearing_q && (!valid_s1 || commit);
	assign accept    = req_valid && req_ready;

	// Clearing pass over the upper store entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= HAS_HI;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + WORD_W'(1);
			if (clr_cnt_q == CLR_LAST) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign clr.en  = clearing_q;
	assign clr.idx = clr_cnt_q;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
		end
	end

	// Storage of compares and pending bits.
	aclint_cmp_store #(.HART_COUNT(HART_COUNT)) u_cmp (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_word   (req.byte_offset[14:3]),
		.wr        (cmp_wr),
		.clr       (clr),
		.rd_data   (cmp_old),
		.cmp_lines (cmp_lines)
	);

	aclint_soft_store #(.HART_COUNT(HART_COUNT)) u_msw (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_row  (req.byte_offset[14:3]),
		.wr      (msw_wr),
		.clr     (clr),
		.rd_bits (msw_old),
		.lines   (msw_lines)
	);

	aclint_soft_store #(.HART_COUNT(HART_COUNT)) u_ssw (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_row  (req.byte_offset[14:3]),
		.wr      (ssw_wr),
		.clr     (clr),
		.rd_bits (ssw_old),
		.lines   (ssw_lines)
	);

	// Decode and execute the request held in the input stage.
	aclint_exec #(.HART_COUNT(HART_COUNT)) u_exec (
		.item       (item_s1),
		.time_value (time_q),
		.cmp_old    (cmp_old),
		.msw_old    (msw_old),
		.ssw_old    (ssw_old),
		.read_data  (x_read),
		.tick       (x_tick),
		.cmp_wr     (x_cmp_wr),
		.msw_wr     (x_msw_wr),
		.ssw_wr     (x_ssw_wr)
	);

	// State updates take effect only when the request commits.
	always_comb begin
		cmp_wr    = x_cmp_wr;
		cmp_wr.en = x_cmp_wr.en && commit;
		msw_wr    = x_msw_wr;
		msw_wr.en = x_msw_wr.en && commit;
		ssw_wr    = x_ssw_wr;
		ssw_wr.en = x_ssw_wr.en && commit;
	end

	// Machine time counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
		end else if (commit && x_tick) begin
			time_q <= time_q + 64'd1;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rd_q <= x_read;
		end
	end

	// Timer lines; state changes only on commit, so the lines match the held response.
	always_comb begin
		timer_lines = '0;
		for (int h = 0; h < LINE_HARTS; h++) begin
			timer_lines[h] = (time_q >= cmp_lines[h]);
		end
	end

	assign rsp_valid                  = rsp_valid_q;
	assign rsp.read_data              = rd_q;
	assign rsp.timer_irq_lines        = timer_lines;
	assign rsp.machine_soft_irq_lines = msw_lines;
	assign rsp.super_soft_irq_lines   = ssw_lines;

	// The time counter holds or advances by exactly one.
	a_time_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (time_q == $past(time_q)) || (time_q == $past(time_q) + 64'd1))
		else $error("time counter jumped");

	// A response appears only after a request committed from the input stage.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(commit))
		else $error("response without a committed request");

	// Anything but a read returns zero data.
	a_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && (item_s1.operation != OP_READ)) |=> (rd_q == '0))
		else $error("non-read returned data");

	// No request enters while the clearing pass runs.
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1 && !rsp_valid_q)
		else $error("request active during clearing pass");

endmodule
